>>> hdl/text_console_writer_assert.svh
// Assertion macros shared by the console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int MEM_CELLS = 8192;

    localparam int ADDR_W = $clog2(MEM_CELLS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int FUNC_W = 2;

    // Cells in the visible window and the counter that walks them.
    localparam int AREA  = ROWS * COLS;
    localparam int CNT_W = $clog2(AREA);

    // A scroll from a window start at or above this point first relocates.
    localparam int SCROLL_LIMIT = MEM_CELLS - (ROWS + 1) * COLS;

    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] read_addr;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_cell;
        logic [ADDR_W-1:0] cursor_cell;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] read_data;
    } out_item_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ADDR_W-1:0] op_a;
        logic [ADDR_W-1:0] op_b;
    } alu_req_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } vram_req_t;

endpackage

>>> hdl/text_console_writer.sv
`timescale 1ns / 1ps

// Text console writer: keeps a character-cell window inside a 16-bit video memory.
// The s_ channel carries one command per transaction (write a byte, clear memory,
// or read one cell); every command returns exactly one transaction on the m_
// channel with the window start, cursor offset, column, row and read data.
// Attribute and blank cell registers are written through the cfg_ port.
// A scroll walks one row with the shared address adder. A scroll that relocates
// the window first copies the window to the base, reading and then writing each
// cell. A clear refills the whole memory with the blank cell. The next command
// can be accepted once the previous result is offered. The address adder and
// the single write port of the video memory pace these steps. After reset the
// memory is filled with the reset blank cell, during which s_ready stays low;
// configuration writes are still taken. Results sit in an output register, so
// the block accepts the next command while a result waits; it only stalls when
// a second result is ready and the first is not taken.

module text_console_writer (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcw_pkg::in_item_t                s_data,

    output logic                             m_valid,
    input  logic                             m_ready,
    output tcw_pkg::out_item_t               m_data,

    input  logic                             cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import tcw_pkg::*;

    `include "text_console_writer_assert.svh"

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DOWN,
        S_COPY_RD,
        S_COPY_WR,
        S_RELOC,
        S_BLANK_SET,
        S_BLANK,
        S_ADV_WIN,
        S_ADV_CUR,
        S_COL0,
        S_PRINT,
        S_EMIT
    } state_t;

    state_t             state_reg;

    // Console state.
    logic [ADDR_W-1:0]  ws_reg;
    logic [ADDR_W-1:0]  off_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic [CELL_W-1:0]  blank_reg;

    // Per-command working registers.
    in_item_t           item_reg;
    logic               col0_pend_reg;
    logic               print_pend_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CELL_W-1:0]  fill_val_reg;
    logic               init_fill_reg;
    logic [CELL_W-1:0]  rdata_reg;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    alu_req_t           alu_req;
    logic [ADDR_W-1:0]  alu_res;
    vram_req_t          vram_req;
    logic [CELL_W-1:0]  vram_rdata;

    logic               is_write;
    logic               is_bs_act;
    logic               is_del;
    logic               at_wrap;
    logic               can_step_down;
    logic               needs_reloc;
    state_t             after_move;

    tcw_addr_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    tcw_vram u_vram (
        .aclk    (aclk),
        .req     (vram_req),
        .rd_data (vram_rdata)
    );

    assign is_write      = (item_reg.func == FUNC_WRITE);
    assign is_bs_act     = is_write && (item_reg.ch == CH_BS) && (col_reg != '0);
    assign is_del        = is_write && (item_reg.ch == CH_DEL);
    assign at_wrap       = (col_reg >= COL_W'(COLS));
    assign can_step_down = (row_reg < ROW_W'(ROWS - 1));
    assign needs_reloc   = (ws_reg >= ADDR_W'(SCROLL_LIMIT));

    // Where a vertical move continues once the cursor has gone down a row.
    always_comb begin
        priority if (col0_pend_reg) begin
            after_move = S_COL0;
        end else if (print_pend_reg) begin
            after_move = S_PRINT;
        end else begin
            after_move = S_EMIT;
        end
    end

    // Operand selection for the shared address adder, one use per state.
    always_comb begin
        alu_req.op   = ALU_ADD;
        alu_req.op_a = off_reg;
        alu_req.op_b = ADDR_W'(1);
        unique case (state_reg)
            S_DECODE: begin
                // Backspace steps back one cell; a pending wrap steps back a row.
                alu_req.op = ALU_SUB;
                if (!is_bs_act) begin
                    alu_req.op_b = ADDR_W'(COLS);
                end
            end
            S_DOWN, S_ADV_CUR: begin
                alu_req.op_b = ADDR_W'(COLS);
            end
            S_COPY_RD: begin
                alu_req.op_a = ws_reg;
                alu_req.op_b = ADDR_W'(cnt_reg);
            end
            S_RELOC: begin
                alu_req.op   = ALU_SUB;
                alu_req.op_b = ws_reg;
            end
            S_BLANK_SET: begin
                alu_req.op_a = ws_reg;
                alu_req.op_b = ADDR_W'(AREA);
            end
            S_ADV_WIN: begin
                alu_req.op_a = ws_reg;
                alu_req.op_b = ADDR_W'(COLS);
            end
            S_COL0: begin
                alu_req.op   = ALU_SUB;
                alu_req.op_b = ADDR_W'(col_reg);
            end
            S_BLANK, S_FILL: begin
                alu_req.op_a = ptr_reg;
            end
            default: begin
                alu_req.op_a = off_reg;
            end
        endcase
    end

    // Video memory requests.
    always_comb begin
        vram_req.wr_en   = 1'b0;
        vram_req.wr_addr = off_reg;
        vram_req.wr_data = blank_reg;
        vram_req.rd_en   = 1'b0;
        vram_req.rd_addr = item_reg.read_addr;
        unique case (state_reg)
            S_DECODE: begin
                vram_req.rd_en = (item_reg.func == FUNC_READ);
                if (is_bs_act) begin
                    vram_req.wr_en   = 1'b1;
                    vram_req.wr_addr = alu_res;
                end else if (is_del) begin
                    vram_req.wr_en = 1'b1;
                end
            end
            S_COPY_RD: begin
                vram_req.rd_en   = 1'b1;
                vram_req.rd_addr = alu_res;
            end
            S_COPY_WR: begin
                vram_req.wr_en   = 1'b1;
                vram_req.wr_addr = ADDR_W'(cnt_reg);
                vram_req.wr_data = vram_rdata;
            end
            S_BLANK: begin
                vram_req.wr_en   = 1'b1;
                vram_req.wr_addr = ptr_reg;
            end
            S_PRINT: begin
                vram_req.wr_en   = 1'b1;
                vram_req.wr_data = {attr_reg, item_reg.ch};
            end
            S_FILL: begin
                vram_req.wr_en   = 1'b1;
                vram_req.wr_addr = ptr_reg;
                vram_req.wr_data = fill_val_reg;
            end
            default: begin
                vram_req.wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer, console state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_FILL;
            ws_reg         <= '0;
            off_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            blank_reg      <= BLANK_RESET;
            ptr_reg        <= '0;
            fill_val_reg   <= BLANK_RESET;
            init_fill_reg  <= 1'b1;
            col0_pend_reg  <= 1'b0;
            print_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ATTR:  attr_reg  <= cfg_wdata[ATTR_W-1:0];
                    REG_BLANK: blank_reg <= cfg_wdata[CELL_W-1:0];
                    default:   attr_reg  <= attr_reg;
                endcase
            end

            // In S_EMIT the output register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_FILL: begin
                    ptr_reg <= alu_res;
                    if (ptr_reg == ADDR_W'(MEM_CELLS - 1)) begin
                        init_fill_reg <= 1'b0;
                        state_reg     <= init_fill_reg ? S_IDLE : S_EMIT;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    rdata_reg <= '0;
                    unique case (item_reg.func)
                        FUNC_WRITE: begin
                            unique case (item_reg.ch)
                                CH_NUL, CH_BEL, CH_HT, CH_VT: begin
                                    state_reg <= S_EMIT;
                                end
                                CH_BS: begin
                                    if (is_bs_act) begin
                                        off_reg <= alu_res;
                                        col_reg <= col_reg - COL_W'(1);
                                    end
                                    state_reg <= S_EMIT;
                                end
                                CH_LF: begin
                                    col0_pend_reg <= 1'b1;
                                    state_reg     <= S_DOWN;
                                end
                                CH_FF: begin
                                    state_reg <= S_DOWN;
                                end
                                CH_CR: begin
                                    state_reg <= S_COL0;
                                end
                                CH_DEL: begin
                                    state_reg <= S_EMIT;
                                end
                                default: begin
                                    // Printable byte: a pending wrap first moves to the
                                    // start of the next row.
                                    print_pend_reg <= 1'b1;
                                    if (at_wrap) begin
                                        off_reg   <= alu_res;
                                        col_reg   <= '0;
                                        state_reg <= S_DOWN;
                                    end else begin
                                        state_reg <= S_PRINT;
                                    end
                                end
                            endcase
                        end
                        FUNC_CLEAR: begin
                            ws_reg       <= '0;
                            off_reg      <= '0;
                            col_reg      <= '0;
                            row_reg      <= '0;
                            ptr_reg      <= '0;
                            fill_val_reg <= blank_reg;
                            state_reg    <= S_FILL;
                        end
                        FUNC_READ: begin
                            state_reg <= S_READ;
                        end
                        default: begin
                            state_reg <= S_EMIT;
                        end
                    endcase
                end
                S_READ: begin
                    rdata_reg <= vram_rdata;
                    state_reg <= S_EMIT;
                end
                S_DOWN: begin
                    cnt_reg <= '0;
                    priority if (can_step_down) begin
                        row_reg   <= row_reg + ROW_W'(1);
                        off_reg   <= alu_res;
                        state_reg <= after_move;
                    end else if (needs_reloc) begin
                        state_reg <= S_COPY_RD;
                    end else begin
                        state_reg <= S_BLANK_SET;
                    end
                end
                S_COPY_RD: begin
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (cnt_reg == CNT_W'(AREA - 1)) begin
                        state_reg <= S_RELOC;
                    end else begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        state_reg <= S_COPY_RD;
                    end
                end
                S_RELOC: begin
                    off_reg   <= alu_res;
                    ws_reg    <= '0;
                    state_reg <= S_BLANK_SET;
                end
                S_BLANK_SET: begin
                    ptr_reg   <= alu_res;
                    cnt_reg   <= '0;
                    state_reg <= S_BLANK;
                end
                S_BLANK: begin
                    ptr_reg <= alu_res;
                    if (cnt_reg == CNT_W'(COLS - 1)) begin
                        state_reg <= S_ADV_WIN;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_ADV_WIN: begin
                    ws_reg    <= alu_res;
                    state_reg <= S_ADV_CUR;
                end
                S_ADV_CUR: begin
                    off_reg   <= alu_res;
                    state_reg <= after_move;
                end
                S_COL0: begin
                    off_reg   <= alu_res;
                    col_reg   <= '0;
                    state_reg <= print_pend_reg ? S_PRINT : S_EMIT;
                end
                S_PRINT: begin
                    off_reg   <= alu_res;
                    col_reg   <= col_reg + COL_W'(1);
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // Wait only if the previous result is still waiting. The pending
                    // moves are cleared here so the next command starts without them.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.start_cell  <= ws_reg;
                        m_data_reg.cursor_cell <= off_reg;
                        m_data_reg.column      <= col_reg;
                        m_data_reg.row         <= row_reg;
                        m_data_reg.read_data   <= rdata_reg;
                        col0_pend_reg          <= 1'b0;
                        print_pend_reg         <= 1'b0;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One command at a time: accepting a transaction closes the input.
    `TCW_ASSERT_NEXT(a_one_cmd, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted twice")

    // Between commands the cursor lies inside the window.
    `TCW_ASSERT_SAME(a_cursor_in_window, aclk, aresetn, state_reg == S_IDLE,
        (row_reg < ROW_W'(ROWS)) && (col_reg <= COL_W'(COLS)), "cursor outside window")

    // A relocating copy only runs for a window near the end of memory.
    `TCW_ASSERT_SAME(a_copy_high_window, aclk, aresetn, state_reg == S_COPY_WR,
        ws_reg >= ADDR_W'(SCROLL_LIMIT), "copy from a low window")

endmodule

>>> hdl/tcw_addr_alu.sv
`timescale 1ns / 1ps

module tcw_addr_alu (
    input  tcw_pkg::alu_req_t            req,
    output logic [tcw_pkg::ADDR_W-1:0]   result
);
    import tcw_pkg::*;

    // Offsets wrap at the end of video memory, which is a power of two.
    always_comb begin
        unique case (req.op)
            ALU_ADD: result = req.op_a + req.op_b;
            ALU_SUB: result = req.op_a - req.op_b;
            default: result = req.op_a;
        endcase
    end

endmodule

>>> hdl/tcw_vram.sv
`timescale 1ns / 1ps

module tcw_vram (
    input  logic                         aclk,
    input  tcw_pkg::vram_req_t           req,
    output logic [tcw_pkg::CELL_W-1:0]   rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] cells [MEM_CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            cells[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= cells[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the text console writer. Commands are driven on the s_ channel
// and every command must come back as exactly one status transaction on the m_
// channel. The testbench keeps its own image of the video memory, the window
// and the cursor, and from it works out the status that each accepted command
// must produce. Both channels idle at random in most of the run.
module tb_top;
    import tcw_pkg::*;

    // The package names the three defined functions; the fourth code is unused
    // and must leave the console untouched.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Bounds of the plain printable range used for runs of text.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    localparam int PHASES     = 7;
    localparam int PHASE_ITEMS = 175;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Image of the console as the block should hold it.
    logic [CELL_W-1:0] vram_image [MEM_CELLS];
    int unsigned       win_start;
    int unsigned       cur_off;
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr_reg;
    logic [CELL_W-1:0] blank_reg;

    // Status transactions still owed by the block, oldest first.
    out_item_t status_due [$];

    int mismatch_count = 0;
    int idle_pct       = 30;
    int stall_left     = 0;

    text_console_writer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Console image
    // ------------------------------------------------------------------

    function automatic void vram_fill();
        for (int i = 0; i < MEM_CELLS; i++)
            vram_image[i] = blank_reg;
    endfunction

    // Moves the cursor down one row. On the bottom row the window scrolls
    // instead: when the row below the window would reach or run past the end of memory,
    // the window is first copied to the base, lowest cell first, and the
    // cursor follows it. Then the incoming row is blanked.
    function automatic void cursor_line_down();
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            cur_off = (cur_off + COLS) % MEM_CELLS;
        end else begin
            if (win_start + AREA + COLS >= MEM_CELLS) begin
                for (int unsigned i = 0; i < AREA; i++)
                    vram_image[i] = vram_image[(win_start + i) % MEM_CELLS];
                cur_off = (cur_off + MEM_CELLS - (win_start % MEM_CELLS)) % MEM_CELLS;
                win_start = 0;
            end
            for (int unsigned i = 0; i < COLS; i++)
                vram_image[(win_start + AREA + i) % MEM_CELLS] = blank_reg;
            win_start = (win_start + COLS) % MEM_CELLS;
            cur_off = (cur_off + COLS) % MEM_CELLS;
        end
    endfunction

    function automatic void cursor_home_col();
        cur_off = (cur_off + MEM_CELLS - cur_col) % MEM_CELLS;
        cur_col = 0;
    endfunction

    // Applies one command to the image and returns the status it must report.
    function automatic out_item_t compute_status(input in_item_t cmd);
        out_item_t         st;
        logic [CELL_W-1:0] rd;
        rd = '0;
        case (cmd.func)
            FUNC_WRITE: begin
                case (cmd.ch)
                    CH_NUL, CH_BEL, CH_HT, CH_VT: ;
                    CH_BS: begin
                        // Backspace never leaves the current row.
                        if (cur_col != 0) begin
                            cur_col--;
                            cur_off = (cur_off + MEM_CELLS - 1) % MEM_CELLS;
                            vram_image[cur_off] = blank_reg;
                        end
                    end
                    CH_LF: begin
                        cursor_line_down();
                        cursor_home_col();
                    end
                    CH_FF: cursor_line_down();
                    CH_CR: cursor_home_col();
                    // At a pending wrap this blanks the first cell after the row.
                    CH_DEL: vram_image[cur_off % MEM_CELLS] = blank_reg;
                    default: begin
                        // A pending wrap is resolved before the byte is stored.
                        if (cur_col >= COLS) begin
                            cur_col -= COLS;
                            cur_off = (cur_off + MEM_CELLS - COLS) % MEM_CELLS;
                            cursor_line_down();
                        end
                        vram_image[cur_off % MEM_CELLS] = {attr_reg, cmd.ch};
                        cur_off = (cur_off + 1) % MEM_CELLS;
                        cur_col++;
                    end
                endcase
            end
            FUNC_CLEAR: begin
                win_start = 0;
                cur_off   = 0;
                cur_col   = 0;
                cur_row   = 0;
                vram_fill();
            end
            FUNC_READ: begin
                if (int'(cmd.read_addr) < MEM_CELLS)
                    rd = vram_image[cmd.read_addr];
            end
            default: ;
        endcase
        st.start_cell  = ADDR_W'(win_start);
        st.cursor_cell = ADDR_W'(cur_off);
        st.column      = COL_W'(cur_col);
        st.row         = ROW_W'(cur_row);
        st.read_data   = rd;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic in_item_t make_cmd(input logic [FUNC_W-1:0] f,
                                          input logic [CHAR_W-1:0] c,
                                          input logic [ADDR_W-1:0] a);
        in_item_t cmd;
        cmd.func      = f;
        cmd.ch        = c;
        cmd.read_addr = a;
        return cmd;
    endfunction

    // Sends one command transaction. The caller is always at a rising edge.
    // When no gap is taken, valid simply stays high and the payload changes at
    // the edge that accepted the previous transaction.
    task automatic send_cmd(input in_item_t cmd);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        status_due.push_back(compute_status(cmd));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] c);
        send_cmd(make_cmd(FUNC_WRITE, c, ADDR_W'($urandom)));
    endtask

    task automatic send_read(input int unsigned addr);
        send_cmd(make_cmd(FUNC_READ, CHAR_W'($urandom), ADDR_W'(addr)));
    endtask

    task automatic send_text(input int count);
        repeat (count) send_byte(CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)));
    endtask

    // Drops valid and waits until every owed status has arrived, then lets the
    // block settle before anything else happens.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (status_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ATTR)
            attr_reg = value[ATTR_W-1:0];
        else
            blank_reg = value[CELL_W-1:0];
        @(posedge aclk);
    endtask

    // Picks one random command. Most are byte writes with a mix that moves the
    // cursor down often enough to keep the window scrolling; the rest are reads,
    // the unused code and an occasional clear.
    function automatic in_item_t pick_console_cmd();
        int                r;
        int                k;
        logic [CHAR_W-1:0] c;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 999);
        c = CHAR_W'($urandom);
        a = ADDR_W'($urandom);
        if (r < 3)
            return make_cmd(FUNC_CLEAR, c, a);
        if (r < 20)
            return make_cmd(FUNC_UNUSED, c, a);
        if (r < 100) begin
            // Half of the reads look inside the visible window.
            if ($urandom_range(0, 1) == 0)
                a = ADDR_W'((win_start + $urandom_range(0, AREA - 1)) % MEM_CELLS);
            return make_cmd(FUNC_READ, c, a);
        end
        k = $urandom_range(0, 99);
        if (k < 45)
            c = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
        else if (k < 60)
            c = CH_LF;
        else if (k < 65)
            c = CH_CR;
        else if (k < 70)
            c = CH_FF;
        else if (k < 76)
            c = CH_BS;
        else if (k < 80)
            c = CH_DEL;
        else if (k < 84) begin
            case ($urandom_range(0, 3))
                0:       c = CH_NUL;
                1:       c = CH_BEL;
                2:       c = CH_HT;
                default: c = CH_VT;
            endcase
        end
        return make_cmd(FUNC_WRITE, c, a);
    endfunction

    // ------------------------------------------------------------------
    // Receiving and checking
    // ------------------------------------------------------------------

    // The receiver stalls in bursts when idling is enabled.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted status transaction is matched against the oldest one owed.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected status: start=%0d cursor=%0d col=%0d row=%0d data=%h",
                             m_data.start_cell, m_data.cursor_cell, m_data.column,
                             m_data.row, m_data.read_data);
            end else begin
                want = status_due.pop_front();
                if (m_data.start_cell !== want.start_cell ||
                    m_data.cursor_cell !== want.cursor_cell ||
                    m_data.column !== want.column ||
                    m_data.row !== want.row ||
                    m_data.read_data !== want.read_data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"status mismatch: expected start=%0d cursor=%0d col=%0d ",
                                  "row=%0d data=%h, got start=%0d cursor=%0d col=%0d ",
                                  "row=%0d data=%h"},
                                 want.start_cell, want.cursor_cell, want.column,
                                 want.row, want.read_data, m_data.start_cell,
                                 m_data.cursor_cell, m_data.column, m_data.row,
                                 m_data.read_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the whole memory holds the reset blank cell. The
    // first command also has to wait out the clearing pass after reset.
    task automatic test_reset_contents();
        send_read(0);
        send_read(MEM_CELLS - 1);
        send_read($urandom_range(0, MEM_CELLS - 1));
        send_cmd(make_cmd(FUNC_UNUSED, '1, '1));
    endtask

    // Every byte class once: printable bytes including high and control ones,
    // the ignored codes, backspace in and at the first column, delete, and the
    // three cursor movers.
    task automatic test_byte_codes();
        send_byte(8'h41);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
        send_byte(CH_BEL);
        send_byte(CH_HT);
        send_byte(CH_VT);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(CH_CR);
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(8'h42);
        send_byte(CH_FF);
        send_read(1);
        send_read(3);
        send_read(COLS);
    endtask

    // Both registers at their extremes, with clears so that the blank value
    // reaches the whole memory. The unused upper byte of an attribute write
    // carries junk that must be dropped.
    task automatic test_register_extremes();
        wait_quiet();
        set_register(REG_ATTR, 16'hA5FF);
        set_register(REG_BLANK, 16'hFFFF);
        send_byte(CH_TILDE);
        send_byte(CH_BS);
        send_read(cur_off);
        send_cmd(make_cmd(FUNC_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom)));
        send_read(MEM_CELLS - 1);
        wait_quiet();
        set_register(REG_ATTR, 16'h5A00);
        set_register(REG_BLANK, 16'h0000);
        send_cmd(make_cmd(FUNC_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom)));
        send_byte(CH_SPACE);
        send_read(0);
        send_read(1);
        wait_quiet();
        set_register(REG_ATTR, {8'h00, ATTR_RESET});
        set_register(REG_BLANK, BLANK_RESET);
    endtask

    // Full rows of text reach the pending wrap column. Delete, backspace, line
    // feed and form feed are each tried while the wrap is pending.
    task automatic test_line_wrap();
        send_byte(CH_CR);
        send_text(COLS);
        send_byte(CH_DEL);
        send_read(cur_off);
        send_byte(CH_BS);
        send_text(2);
        send_text(COLS - 1);
        send_byte(CH_LF);
        send_text(COLS);
        send_byte(CH_FF);
        send_text(1);
        send_read(cur_off - 1);
    endtask

    // Enough line moves to scroll the window all the way to the end of memory
    // so that it is copied back to the base, then a wrap on the bottom row.
    task automatic test_scroll_relocate();
        int k;
        repeat (170) begin
            k = $urandom_range(0, 9);
            if (k < 6)
                send_byte(CH_LF);
            else if (k < 8)
                send_byte(CH_FF);
            else if (k < 9)
                send_text(1);
            else
                send_read((win_start + $urandom_range(0, AREA - 1)) % MEM_CELLS);
        end
        send_byte(CH_CR);
        send_text(COLS + 1);
        send_read(win_start);
        send_read((win_start + AREA - 1) % MEM_CELLS);
    endtask

    // Random traffic in phases, each under its own register setting and its
    // own amount of idling. Phase 1 and the last phase run without idling.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] attr_val;
        logic [CFG_DATA_W-1:0] blank_val;
        int                    n;
        int                    run;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_quiet();
            attr_val  = CFG_DATA_W'($urandom);
            blank_val = CFG_DATA_W'($urandom);
            case (phase)
                0: begin
                    attr_val  = '0;
                    blank_val = '0;
                end
                1: begin
                    attr_val  = '1;
                    blank_val = '1;
                end
                4: begin
                    attr_val  = {8'h00, ATTR_RESET};
                    blank_val = BLANK_RESET;
                end
                default: ;
            endcase
            set_register(REG_ATTR, attr_val);
            set_register(REG_BLANK, blank_val);
            if (phase == PHASES - 1 || phase == 1)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(10, 50);
            n = 0;
            while (n < PHASE_ITEMS) begin
                // Now and then a long run of text, so rows fill up and wrap.
                if ($urandom_range(0, 99) == 0) begin
                    run = $urandom_range(60, 100);
                    send_text(run);
                    n += run;
                end else begin
                    send_cmd(pick_console_cmd());
                    n++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        attr_reg  = ATTR_RESET;
        blank_reg = BLANK_RESET;
        vram_fill();
        win_start = 0;
        cur_off   = 0;
        cur_col   = 0;
        cur_row   = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_contents();
        test_byte_codes();
        test_register_extremes();
        test_line_wrap();
        test_scroll_relocate();
        test_random_traffic();

        // Let any stray transaction show up before the verdict.
        wait_quiet();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && status_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, clears and window copies
    // included.
    initial begin
        #(30_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
